### sv/rcct_pkg.sv
// Shared constants, codes and control structs of the raycast column texturer.
`timescale 1ns / 1ps

package rcct_pkg;

	// Field and register widths
	localparam int ROW_BITS    = 12;
	localparam int FRAC_BITS   = 16;
	localparam int CNT_W       = 13;
	localparam int H_BITS      = 12;
	localparam int COLOR_BITS  = 24;
	localparam int TEX_BITS    = 12;
	localparam int DIST_BITS   = 20;
	localparam int DIST_FRAC   = 10;
	localparam int WFRAC_BITS  = 16;
	localparam int FACE_BITS   = 2;
	localparam int KIND_BITS   = 2;
	localparam int POS_BITS    = 32;
	localparam int CFG_IDX_W   = 3;

	// Line height = (h << 10) / dist, at most H_BITS + DIST_FRAC bits
	localparam int LH_BITS       = H_BITS + DIST_FRAC;
	localparam int STEP_NUM_BITS = TEX_BITS + FRAC_BITS;
	localparam int DIV_NUM_BITS  = (LH_BITS > STEP_NUM_BITS) ? LH_BITS : STEP_NUM_BITS;
	localparam int DIV_DEN_BITS  = LH_BITS;
	localparam int DIV_CNT_BITS  = $clog2(DIV_NUM_BITS);
	localparam int OFS_BITS      = LH_BITS - 1;
	localparam int TY_BITS       = POS_BITS - FRAC_BITS;

	// Reset values of the configuration registers
	localparam logic [H_BITS-1:0]   SCREEN_HEIGHT_RST = H_BITS'(480);
	localparam logic [TEX_BITS-1:0] TEXTURE_SIZE_RST  = TEX_BITS'(64);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT = 3'd4;

	// Input opcodes
	localparam logic OP_SETUP = 1'b0;
	localparam logic OP_ROW   = 1'b1;

	// Pixel kinds
	localparam logic [KIND_BITS-1:0] KIND_CEILING = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_WALL    = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_FLOOR   = 2'd2;

	// Divider operand select
	typedef enum logic {
		DIV_SEL_LH   = 1'b0,
		DIV_SEL_STEP = 1'b1
	} div_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     setup;
		logic     row_step;
		logic     div_start;
		div_sel_t div_sel;
		logic     lh_capture;
		logic     span_calc;
		logic     step_capture;
		logic     finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic out_hold;
	} status_t;

endpackage

### sv/raycast_column_texturer_core.sv
// Top level of the raycast column texturer: ports, packing and controller/datapath wiring.
//
// Channel  Dir  Handshake           Contents
// s_*      in   s_tvalid/s_tready   tuser opcode; tdata distance, fraction, face
// m_*      out  m_tvalid/m_tready   tuser pixel kind; tdata row..face; tlast last row
// cfg_*    in   cfg_valid/cfg_ready register index and data, always ready
//
// Rows stream at one per cycle while results are taken.
// A column setup item runs the shared divider, which forms one quotient bit per cycle,
// first for line height, then for step.
// s_tready drops during setup and while a result waits in the output register unseen.
// arst_n resets all control and column state at once; no clearing pass follows.
`timescale 1ns / 1ps

module raycast_column_texturer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // perp_distance[19:0], wall_fraction[35:20], face[37:36]
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // row[11:0], color[35:12], texel_column[47:36],
	                               // texel_row[59:48], texture_face[61:60]
	output logic [1:0]  m_tuser,   // pixel_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import rcct_pkg::*;

	cmd_t                  cmd;
	status_t               status;
	logic [11:0]           out_row;
	logic [KIND_BITS-1:0]  out_kind;
	logic [COLOR_BITS-1:0] out_color;
	logic [TEX_BITS-1:0]   out_tcol;
	logic [TEX_BITS-1:0]   out_trow;
	logic [FACE_BITS-1:0]  out_face;

	assign cfg_ready = 1'b1;

	rcct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_opcode (s_tuser),
		.in_ready  (s_tready),
		.status    (status),
		.cmd       (cmd)
	);

	rcct_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.in_distance      (s_tdata[19:0]),
		.in_fraction      (s_tdata[35:20]),
		.in_face          (s_tdata[37:36]),
		.cfg_we           (cfg_valid),
		.cfg_idx          (cfg_index),
		.cfg_value        (cfg_data),
		.out_ready        (m_tready),
		.out_valid        (m_tvalid),
		.out_row          (out_row),
		.out_kind         (out_kind),
		.out_color        (out_color),
		.out_texel_column (out_tcol),
		.out_texel_row    (out_trow),
		.out_face         (out_face),
		.out_last         (m_tlast)
	);

	// Pack result fields, lowest first
	assign m_tdata = {2'b00, out_face, out_trow, out_tcol, out_color, out_row};
	assign m_tuser = out_kind;

endmodule

### sv/rcct_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rcct_divider (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [rcct_pkg::DIV_NUM_BITS-1:0]     numer,
	input  logic [rcct_pkg::DIV_DEN_BITS-1:0]     denom,
	output logic [rcct_pkg::DIV_NUM_BITS-1:0]     quotient,
	output logic                                  done
);
	import rcct_pkg::*;

	logic [DIV_NUM_BITS-1:0] quo_q;
	logic [DIV_DEN_BITS-1:0] rem_q;
	logic [DIV_DEN_BITS-1:0] den_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DIV_DEN_BITS:0]   rem_shift;
	logic [DIV_DEN_BITS:0]   rem_diff;
	logic                    fits;

	// Shift in the next numerator bit and trial-subtract
	always_comb begin
		rem_shift = {rem_q, quo_q[DIV_NUM_BITS-1]};
		rem_diff  = rem_shift - {1'b0, den_q};
		fits      = rem_shift >= {1'b0, den_q};
	end

	// Control: count iterations, pulse done after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIV_NUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits replace numerator bits from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[DIV_DEN_BITS-1:0] : rem_shift[DIV_DEN_BITS-1:0];
			quo_q <= {quo_q[DIV_NUM_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### sv/rcct_datapath.sv
// Datapath: configuration, column setup arithmetic, row stepping and output register.
`timescale 1ns / 1ps

module rcct_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rcct_pkg::cmd_t                       cmd,
	output rcct_pkg::status_t                    status,
	input  logic [rcct_pkg::DIST_BITS-1:0]       in_distance,
	input  logic [rcct_pkg::WFRAC_BITS-1:0]      in_fraction,
	input  logic [rcct_pkg::FACE_BITS-1:0]       in_face,
	input  logic                                 cfg_we,
	input  logic [rcct_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [rcct_pkg::COLOR_BITS-1:0]      cfg_value,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [11:0]                          out_row,
	output logic [rcct_pkg::KIND_BITS-1:0]       out_kind,
	output logic [rcct_pkg::COLOR_BITS-1:0]      out_color,
	output logic [rcct_pkg::TEX_BITS-1:0]        out_texel_column,
	output logic [rcct_pkg::TEX_BITS-1:0]        out_texel_row,
	output logic [rcct_pkg::FACE_BITS-1:0]       out_face,
	output logic                                 out_last
);
	import rcct_pkg::*;

	// Configuration registers
	logic [H_BITS-1:0]     screen_height_q;
	logic [COLOR_BITS-1:0] ceiling_color_q;
	logic [COLOR_BITS-1:0] floor_color_q;
	logic [TEX_BITS-1:0]   texture_width_q;
	logic [TEX_BITS-1:0]   texture_height_q;

	// Column state
	logic [CNT_W-1:0]      row_cnt_q;
	logic [ROW_BITS-1:0]   span_start_q;
	logic [ROW_BITS-1:0]   span_end_q;
	logic [TEX_BITS-1:0]   column_texel_q;
	logic [POS_BITS-1:0]   tex_pos_q;
	logic [POS_BITS-1:0]   tex_step_q;
	logic [FACE_BITS-1:0]  face_q;

	// Setup scratch
	logic [WFRAC_BITS-1:0] frac_q;
	logic [LH_BITS-1:0]    lh_q;
	logic [OFS_BITS-1:0]   offset_q;

	// Output register
	logic                  out_valid_q;
	logic [11:0]           out_row_q;
	logic [KIND_BITS-1:0]  out_kind_q;
	logic [COLOR_BITS-1:0] out_color_q;
	logic [TEX_BITS-1:0]   out_tcol_q;
	logic [TEX_BITS-1:0]   out_trow_q;
	logic [FACE_BITS-1:0]  out_face_q;
	logic                  out_last_q;

	// Divider
	logic [DIV_NUM_BITS-1:0] div_numer;
	logic [DIV_DEN_BITS-1:0] div_denom;
	logic [DIV_NUM_BITS-1:0] div_quo;
	logic                    div_done;

	// Setup combinational terms
	logic [LH_BITS-2:0]                 half_l;
	logic [H_BITS-2:0]                  half_h;
	logic                               half_ge;
	logic [LH_BITS-1:0]                 end_sum;
	logic [ROW_BITS-1:0]                start_val;
	logic [ROW_BITS-1:0]                end_val;
	logic [OFS_BITS+POS_BITS-1:0]       pos_prod;
	logic [POS_BITS-1:0]                pos_start;
	logic [WFRAC_BITS+TEX_BITS-1:0]     tcol_prod;

	// Row combinational terms
	logic                  produce;
	logic [KIND_BITS-1:0]  kind;
	logic [TY_BITS-1:0]    ty;
	logic [TEX_BITS-1:0]   th_m1;
	logic [TEX_BITS-1:0]   trow;
	logic [POS_BITS:0]     pos_sum;
	logic [POS_BITS-1:0]   pos_next;
	logic [CNT_W-1:0]      row_inc;

	// Pick divider operands: line height first, then texture step
	always_comb begin
		if (cmd.div_sel == DIV_SEL_STEP) begin
			div_numer = DIV_NUM_BITS'({texture_height_q, {FRAC_BITS{1'b0}}});
			div_denom = lh_q;
		end else begin
			div_numer = DIV_NUM_BITS'({screen_height_q, {DIST_FRAC{1'b0}}});
			div_denom = (in_distance == '0) ? DIV_DEN_BITS'(1) : DIV_DEN_BITS'(in_distance);
		end
	end

	rcct_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.numer    (div_numer),
		.denom    (div_denom),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Span, offset and start position terms
	always_comb begin
		half_l  = lh_q[LH_BITS-1:1];
		half_h  = screen_height_q[H_BITS-1:1];
		half_ge = half_l >= (LH_BITS-1)'(half_h);
		end_sum = LH_BITS'(half_l) + LH_BITS'(half_h);
		start_val = half_ge ? '0 : ROW_BITS'(half_h - half_l[H_BITS-2:0]);
		if (screen_height_q == '0) begin
			end_val = '0;
		end else if (end_sum >= LH_BITS'(screen_height_q)) begin
			end_val = ROW_BITS'(screen_height_q - 1'b1);
		end else begin
			end_val = ROW_BITS'(end_sum);
		end
		pos_prod  = (OFS_BITS+POS_BITS)'(offset_q) * (OFS_BITS+POS_BITS)'(tex_step_q);
		pos_start = (pos_prod[OFS_BITS+POS_BITS-1:POS_BITS] != '0) ? '1 :
		            pos_prod[POS_BITS-1:0];
		tcol_prod = (WFRAC_BITS+TEX_BITS)'(frac_q) * (WFRAC_BITS+TEX_BITS)'(texture_width_q);
	end

	// Row classification and texture row
	always_comb begin
		produce = row_cnt_q < CNT_W'(screen_height_q);
		if (row_cnt_q < CNT_W'(span_start_q)) begin
			kind = KIND_CEILING;
		end else if (row_cnt_q < CNT_W'(span_end_q)) begin
			kind = KIND_WALL;
		end else begin
			kind = KIND_FLOOR;
		end
		ty    = tex_pos_q[POS_BITS-1:FRAC_BITS];
		th_m1 = texture_height_q - 1'b1;
		if (texture_height_q == '0) begin
			trow = '0;
		end else if (ty > TY_BITS'(th_m1)) begin
			trow = th_m1;
		end else begin
			trow = ty[TEX_BITS-1:0];
		end
		pos_sum  = {1'b0, tex_pos_q} + {1'b0, tex_step_q};
		pos_next = pos_sum[POS_BITS] ? '1 : pos_sum[POS_BITS-1:0];
		row_inc  = row_cnt_q + 1'b1;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q  <= SCREEN_HEIGHT_RST;
			ceiling_color_q  <= '0;
			floor_color_q    <= '0;
			texture_width_q  <= TEXTURE_SIZE_RST;
			texture_height_q <= TEXTURE_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SCREEN_HEIGHT:  screen_height_q  <= cfg_value[H_BITS-1:0];
				REG_CEILING_COLOR:  ceiling_color_q  <= cfg_value;
				REG_FLOOR_COLOR:    floor_color_q    <= cfg_value;
				REG_TEXTURE_WIDTH:  texture_width_q  <= cfg_value[TEX_BITS-1:0];
				REG_TEXTURE_HEIGHT: texture_height_q <= cfg_value[TEX_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Column state: setup sequence and row stepping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q      <= CNT_W'(SCREEN_HEIGHT_RST);
			span_start_q   <= '0;
			span_end_q     <= '0;
			column_texel_q <= '0;
			tex_pos_q      <= '0;
			tex_step_q     <= '0;
			face_q         <= '0;
		end else begin
			if (cmd.setup) begin
				face_q <= in_face;
			end
			if (cmd.span_calc) begin
				span_start_q <= start_val;
				span_end_q   <= end_val;
			end
			if (cmd.step_capture) begin
				tex_step_q <= (lh_q == '0) ? '0 : POS_BITS'(div_quo);
			end
			if (cmd.finish) begin
				tex_pos_q      <= pos_start;
				column_texel_q <= tcol_prod[WFRAC_BITS+TEX_BITS-1:WFRAC_BITS];
				row_cnt_q      <= '0;
			end
			if (cmd.row_step && produce) begin
				row_cnt_q <= row_inc;
				if (kind == KIND_WALL) begin
					tex_pos_q <= pos_next;
				end
			end
		end
	end

	// Setup scratch registers
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			frac_q <= in_fraction;
		end
		if (cmd.lh_capture) begin
			lh_q <= div_quo[LH_BITS-1:0];
		end
		if (cmd.span_calc) begin
			offset_q <= half_ge ? (half_l - (LH_BITS-1)'(half_h)) : '0;
		end
	end

	// Output valid: load on a producing row, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.row_step && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.row_step && produce) begin
			out_row_q  <= row_cnt_q[11:0];
			out_kind_q <= kind;
			out_last_q <= row_inc == CNT_W'(screen_height_q);
			case (kind)
				KIND_CEILING: begin
					out_color_q <= ceiling_color_q;
					out_tcol_q  <= '0;
					out_trow_q  <= '0;
					out_face_q  <= '0;
				end
				KIND_WALL: begin
					out_color_q <= '0;
					out_tcol_q  <= column_texel_q;
					out_trow_q  <= trow;
					out_face_q  <= face_q;
				end
				default: begin
					out_color_q <= floor_color_q;
					out_tcol_q  <= '0;
					out_trow_q  <= '0;
					out_face_q  <= '0;
				end
			endcase
		end
	end

	assign status.div_done = div_done;
	assign status.out_hold = out_valid_q & ~out_ready;

	assign out_valid        = out_valid_q;
	assign out_row          = out_row_q;
	assign out_kind         = out_kind_q;
	assign out_color        = out_color_q;
	assign out_texel_column = out_tcol_q;
	assign out_texel_row    = out_trow_q;
	assign out_face         = out_face_q;
	assign out_last         = out_last_q;

endmodule

### sv/rcct_ctrl.sv
// Controller: input handshake and column setup sequence.
`timescale 1ns / 1ps

module rcct_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_opcode,
	output logic                 in_ready,
	input  rcct_pkg::status_t    status,
	output rcct_pkg::cmd_t       cmd
);
	import rcct_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_DIV_LH   = 5'b00010,
		ST_SPAN     = 5'b00100,
		ST_DIV_STEP = 5'b01000,
		ST_FINISH   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// Decode commands and next state
	always_comb begin
		in_ready = (state_q == ST_IDLE) && !status.out_hold;
		accept   = in_valid && in_ready;
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_opcode == OP_SETUP) begin
					cmd.setup     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_LH;
					state_d       = ST_DIV_LH;
				end else if (accept) begin
					cmd.row_step = 1'b1;
				end
			end
			ST_DIV_LH: begin
				if (status.div_done) begin
					cmd.lh_capture = 1'b1;
					state_d        = ST_SPAN;
				end
			end
			ST_SPAN: begin
				cmd.span_calc = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_STEP;
				state_d       = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				cmd.div_sel = DIV_SEL_STEP;
				if (status.div_done) begin
					cmd.step_capture = 1'b1;
					state_d          = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### tb/tb_raycast_column_texturer_core.sv
// Self-checking testbench for the raycast column texturer core.
`timescale 1ns / 1ps

module tb_raycast_column_texturer_core;
	import rcct_pkg::*;

	// Settle wait, long enough for a pending setup item to finish
	localparam int SETTLE_CYCLES = 2 * DIV_NUM_BITS + 20;
	localparam int RANDOM_ITEMS  = 850;
	localparam int QUIET_ITEMS   = 150;

	typedef struct {
		logic [ROW_BITS-1:0]   row;
		logic [KIND_BITS-1:0]  kind;
		logic [COLOR_BITS-1:0] color;
		logic [TEX_BITS-1:0]   tcol;
		logic [TEX_BITS-1:0]   trow;
		logic [FACE_BITS-1:0]  face;
		logic                  last;
	} pixel_t;

	// Column texturing predictor with the queue of pixels still to come
	class pixel_scoreboard;
		logic [H_BITS-1:0]     height = SCREEN_HEIGHT_RST;
		logic [COLOR_BITS-1:0] ceil_color = '0;
		logic [COLOR_BITS-1:0] floor_color = '0;
		logic [TEX_BITS-1:0]   tex_w = TEXTURE_SIZE_RST;
		logic [TEX_BITS-1:0]   tex_h = TEXTURE_SIZE_RST;
		logic [CNT_W-1:0]      row_cnt = CNT_W'(480);
		logic [ROW_BITS-1:0]   span_start = '0;
		logic [ROW_BITS-1:0]   span_end = '0;
		logic [TEX_BITS-1:0]   col_texel = '0;
		logic [POS_BITS-1:0]   tex_pos = '0;
		logic [POS_BITS-1:0]   tex_step = '0;
		logic [FACE_BITS-1:0]  face_q = '0;
		pixel_t                expected_pixels[$];
		int                    errors = 0;
		int                    checked = 0;
		int                    columns = 0;

		function logic [POS_BITS-1:0] sat32(logic [63:0] v);
			return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
			case (idx)
				REG_SCREEN_HEIGHT:  height = data[H_BITS-1:0];
				REG_CEILING_COLOR:  ceil_color = data;
				REG_FLOOR_COLOR:    floor_color = data;
				REG_TEXTURE_WIDTH:  tex_w = data[TEX_BITS-1:0];
				REG_TEXTURE_HEIGHT: tex_h = data[TEX_BITS-1:0];
				default: ;
			endcase
		endfunction

		// Advance the column state for one accepted item; return 1 if a pixel is due
		function bit note_item(logic op, logic [DIST_BITS-1:0] distance,
				logic [WFRAC_BITS-1:0] frac, logic [FACE_BITS-1:0] face);
			logic [63:0]        d, h, lh, half_h, half_l, top, bottom, step_q, ofs;
			logic [TY_BITS-1:0] ty;
			pixel_t             px;
			if (op == OP_SETUP) begin
				// Zero distance counts as the smallest one
				d = (distance == '0) ? 64'd1 : 64'(distance);
				h = 64'(height);
				lh = (h << DIST_FRAC) / d;
				half_h = h >> 1;
				half_l = lh >> 1;
				top = (half_l >= half_h) ? 64'd0 : half_h - half_l;
				bottom = half_l + half_h;
				if (h == 64'd0) begin
					bottom = 64'd0;
				end else if (bottom >= h) begin
					bottom = h - 64'd1;
				end
				step_q = (lh == 64'd0) ? 64'd0 : (64'(tex_h) << FRAC_BITS) / lh;
				ofs = top + half_l - half_h;
				span_start = top[ROW_BITS-1:0];
				span_end = bottom[ROW_BITS-1:0];
				col_texel = TEX_BITS'((64'(frac) * 64'(tex_w)) >> 16);
				tex_step = sat32(step_q);
				tex_pos = sat32(ofs * 64'(tex_step));
				face_q = face;
				row_cnt = '0;
				columns++;
				return 1'b0;
			end
			// Rows past the column end are dropped
			if (row_cnt >= CNT_W'(height))
				return 1'b0;
			px.row = row_cnt[ROW_BITS-1:0];
			px.color = '0;
			px.tcol = '0;
			px.trow = '0;
			px.face = '0;
			if (row_cnt < CNT_W'(span_start)) begin
				px.kind = KIND_CEILING;
				px.color = ceil_color;
			end else if (row_cnt < CNT_W'(span_end)) begin
				ty = tex_pos[POS_BITS-1:FRAC_BITS];
				if (tex_h == '0) begin
					ty = '0;
				end else if (ty > TY_BITS'(tex_h - 1'b1)) begin
					ty = TY_BITS'(tex_h - 1'b1);
				end
				px.kind = KIND_WALL;
				px.tcol = col_texel;
				px.trow = ty[TEX_BITS-1:0];
				px.face = face_q;
				tex_pos = sat32(64'(tex_pos) + 64'(tex_step));
			end else begin
				px.kind = KIND_FLOOR;
				px.color = floor_color;
			end
			px.last = (row_cnt + 1'b1 == CNT_W'(height));
			row_cnt = row_cnt + 1'b1;
			expected_pixels.push_back(px);
			return 1'b1;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want,
				logic [ROW_BITS-1:0] row);
			if (got !== want)
				report($sformatf("row %0d %s: got %0h, expected %0h", row, name, got, want));
		endtask

		task check_pixel(logic [63:0] data, logic [KIND_BITS-1:0] kind, logic last);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("pixel for row %0d with none expected", data[11:0]));
				return;
			end
			want = expected_pixels.pop_front();
			checked++;
			compare_field("row", 32'(data[11:0]), 32'(want.row), want.row);
			compare_field("pixel_kind", 32'(kind), 32'(want.kind), want.row);
			compare_field("color", 32'(data[35:12]), 32'(want.color), want.row);
			compare_field("texel_column", 32'(data[47:36]), 32'(want.tcol), want.row);
			compare_field("texel_row", 32'(data[59:48]), 32'(want.trow), want.row);
			compare_field("texture_face", 32'(data[61:60]), 32'(want.face), want.row);
			compare_field("last_row", 32'(last), 32'(want.last), want.row);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // perp_distance[19:0], wall_fraction[35:20], face[37:36]
	logic        s_tuser = 1'b0; // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // row[11:0], color[35:12], texel_column[47:36],
	                             // texel_row[59:48], texture_face[61:60]
	logic [1:0]  m_tuser;        // pixel_kind
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	pixel_scoreboard sb = new();
	bit              idle_on = 1'b1;
	int              useful = 0;
	int              phase = 0;

	raycast_column_texturer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check every pixel taken from the output
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_pixel(m_tdata, m_tuser, m_tlast);
	end

	// Stall the output in short bursts while idling is on
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	task automatic send_item(logic op, logic [DIST_BITS-1:0] distance,
			logic [WFRAC_BITS-1:0] frac, logic [FACE_BITS-1:0] face);
		if (useful >= RANDOM_ITEMS - QUIET_ITEMS)
			idle_on = 1'b0;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, face, frac, distance};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (sb.note_item(op, distance, frac, face) || op == OP_SETUP)
			useful++;
	endtask

	task automatic send_row();
		send_item(OP_ROW, DIST_BITS'($urandom), WFRAC_BITS'($urandom), FACE_BITS'($urandom));
	endtask

	// Drain all pixels, then let a pending setup finish before touching registers
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_all(logic [H_BITS-1:0] h, logic [COLOR_BITS-1:0] ceil_c, floor_c,
			logic [TEX_BITS-1:0] tw, th);
		logic [CFG_IDX_W-1:0] idx [5];
		logic [23:0]          val [5];
		idx = '{REG_SCREEN_HEIGHT, REG_CEILING_COLOR, REG_FLOOR_COLOR,
			REG_TEXTURE_WIDTH, REG_TEXTURE_HEIGHT};
		val = '{24'(h), ceil_c, floor_c, 24'(tw), 24'(th)};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.note_config(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		phase++;
	endtask

	function automatic logic [H_BITS-1:0] pick_height();
		case ($urandom_range(0, 19))
			0:       return H_BITS'(1);
			1:       return {H_BITS{1'b1}};
			2, 3, 4: return H_BITS'($urandom_range(41, 300));
			default: return H_BITS'($urandom_range(2, 40));
		endcase
	endfunction

	function automatic logic [TEX_BITS-1:0] pick_tex();
		case ($urandom_range(0, 9))
			0:       return TEX_BITS'(1);
			1:       return {TEX_BITS{1'b1}};
			2, 3:    return TEX_BITS'($urandom_range(129, 4095));
			default: return TEX_BITS'($urandom_range(2, 128));
		endcase
	endfunction

	function automatic logic [COLOR_BITS-1:0] pick_color();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return {COLOR_BITS{1'b1}};
			default: return COLOR_BITS'($urandom);
		endcase
	endfunction

	// Bias distances toward 1.0 so spans land inside small screens
	function automatic logic [DIST_BITS-1:0] pick_distance();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return DIST_BITS'($urandom_range(256, 8192));
			4, 5:       return DIST_BITS'($urandom_range(1, 255));
			6, 7:       return DIST_BITS'($urandom);
			8:          return $urandom_range(0, 1) ? DIST_BITS'(1) : {DIST_BITS{1'b1}};
			default:    return '0;
		endcase
	endfunction

	// Hard stop for a hung handshake
	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [H_BITS-1:0]   h;
		logic [TEX_BITS-1:0] tw, th;
		int                  n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset leaves the column done: this row is dropped
		send_row();
		settle();
		write_all(12'd8, 24'hFFFFFF, 24'h123456, 12'hFFF, 12'hFFF);
		// Distance 1.0: wall fills the screen, bottom row is floor, one row past the end
		send_item(OP_SETUP, 20'h00400, 16'hFFFF, 2'd3);
		repeat (9) send_row();
		// Farthest distance: zero line height and an empty span
		send_item(OP_SETUP, 20'hFFFFF, 16'h0000, 2'd0);
		repeat (2) send_row();
		// Zero distance taken as the smallest one
		send_item(OP_SETUP, 20'h00000, 16'h8000, 2'd1);
		repeat (3) send_row();
		// Lower the height below the counter, then raise it and resume mid-column
		settle();
		write_all(12'd2, 24'hFFFFFF, 24'h123456, 12'hFFF, 12'hFFF);
		send_row();
		settle();
		write_all(12'd20, 24'hFFFFFF, 24'h123456, 12'hFFF, 12'hFFF);
		repeat (2) send_row();
		// Zero texture sizes
		settle();
		write_all(12'd20, 24'h000000, 24'hFFFFFF, 12'd0, 12'd0);
		send_item(OP_SETUP, 20'h00200, 16'hABCD, 2'd2);
		repeat (2) send_row();
		// Zero screen height: no row gives a pixel
		settle();
		write_all(12'd0, 24'h000000, 24'hFFFFFF, 12'd64, 12'd64);
		send_item(OP_SETUP, 20'h00400, 16'h0000, 2'd0);
		send_row();

		// Random phases of whole columns with random content and some noise
		while (useful < RANDOM_ITEMS) begin
			settle();
			if (useful < RANDOM_ITEMS - QUIET_ITEMS)
				idle_on = ($urandom_range(0, 3) != 0);
			h = pick_height();
			tw = pick_tex();
			th = pick_tex();
			if (phase == 6) h = {H_BITS{1'b1}};
			if (phase == 7) begin
				tw = TEX_BITS'(1);
				th = {TEX_BITS{1'b1}};
			end
			if (phase == 8) begin
				h = H_BITS'(1);
				tw = {TEX_BITS{1'b1}};
				th = TEX_BITS'(1);
			end
			write_all(h, pick_color(), pick_color(), tw, th);
			// Continue the column left open by the previous phase
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4)) send_row();
			repeat ($urandom_range(2, 4)) begin
				if ($urandom_range(0, 7) == 0) begin
					repeat ($urandom_range(1, 3))
						send_item(1'($urandom), DIST_BITS'($urandom),
							WFRAC_BITS'($urandom), FACE_BITS'($urandom));
				end
				send_item(OP_SETUP, pick_distance(), WFRAC_BITS'($urandom),
					FACE_BITS'($urandom));
				n = int'(h) + $urandom_range(0, 2);
				if ($urandom_range(0, 4) == 0)
					n = $urandom_range(0, int'(h));
				if (n > 96)
					n = $urandom_range(40, 96);
				repeat (n) send_row();
			end
		end

		settle();
		$display("Run covered %0d column setups and %0d checked pixels in %0d register phases.",
			sb.columns, sb.checked, phase);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### files.f
sv/rcct_pkg.sv
sv/rcct_divider.sv
sv/rcct_datapath.sv
sv/rcct_ctrl.sv
sv/raycast_column_texturer_core.sv
tb/tb_raycast_column_texturer_core.sv
